[rtl/stp_pkg.sv]
`default_nettype none

package stp_pkg;

    // field widths fixed by the interface
    localparam int TGT_W    = 16;
    localparam int SPD_W    = 8;
    localparam int ACC_W    = 10;
    localparam int SPM_W    = 10;
    localparam int TS_W     = 24;
    localparam int PERIOD_W = 24;
    localparam int STEPS_W  = 21;
    localparam int POS_W    = 20;
    localparam int RAMP_W   = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CNT_W    = 5;

    localparam int RELOAD_BITS_DEF   = 16;
    localparam int VEL_FRAC_BITS_DEF = 16;

    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_MM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_SC  = 3'd4;

    localparam logic [ACC_W-1:0] ACCEL_RST     = 10'd100;
    localparam logic [SPD_W-1:0] MIN_SPEED_RST = 8'd2;
    localparam logic [SPD_W-1:0] MAX_SPEED_RST = 8'd60;
    localparam logic [SPM_W-1:0] STEPS_MM_RST  = 10'd25;
    localparam logic [TS_W-1:0]  TIMER_SC_RST  = 24'd2000000;

    localparam logic [SPD_W-1:0]    VEL_RST_MM_S = 8'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd167772;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 24'hFFFFFF;
    localparam logic [STEPS_W-1:0]  STEPS_MAX    = 21'h1FFFFF;
    localparam logic [POS_W-1:0]    POS_MAX      = 20'hFFFFF;

    // serial iteration counts, one per multiplier digit or quotient bit
    localparam logic [CNT_W-1:0] CNT_SPM  = 5'd10;
    localparam logic [CNT_W-1:0] CNT_SPD  = 5'd8;
    localparam logic [CNT_W-1:0] CNT_ACC  = 5'd10;
    localparam logic [CNT_W-1:0] CNT_TS   = 5'd24;
    localparam logic [CNT_W-1:0] CNT_RAMP = 5'd26;
    localparam logic [CNT_W-1:0] CNT_PER  = 5'd24;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } unit_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MV_TGT_GO,
        ST_MV_TGT_WAIT,
        ST_MV_DIST,
        ST_MV_SQ_GO,
        ST_MV_SQ_WAIT,
        ST_MV_SPM_GO,
        ST_MV_SPM_WAIT,
        ST_MV_RAMP_GO,
        ST_MV_RAMP_WAIT,
        ST_MV_RAMP_SET,
        ST_TK_DV_GO,
        ST_TK_DV_WAIT,
        ST_TK_NV,
        ST_TK_VEL,
        ST_PER_GO,
        ST_PER_MUL_WAIT,
        ST_PER_CHK,
        ST_PER_DIV_GO,
        ST_PER_DIV_WAIT,
        ST_FIN,
        ST_RL_GO,
        ST_RL_WAIT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[rtl/stp_serial_mul.sv]
`default_nettype none

module stp_serial_mul #(
    parameter int AW = 24,
    parameter int BW = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire stp_pkg::unit_ctl_t    ctl,
    input  wire logic [AW-1:0]         a_in,
    input  wire logic [BW-1:0]         b_in,
    output logic                       done,
    output logic [AW+BW-1:0]           prod
);

    localparam int PW = AW + BW;

    logic [PW-1:0]             a_sh_reg;
    logic [BW-1:0]             b_sh_reg;
    logic [PW-1:0]             acc_reg;
    logic [stp_pkg::CNT_W-1:0] cnt_reg;
    logic                      run_reg;
    logic                      done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                run_reg <= 1'b1;
            end else if (run_reg && cnt_reg == stp_pkg::CNT_W'(1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one multiplier bit per cycle, LSB first
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            a_sh_reg <= PW'(a_in);
            b_sh_reg <= b_in;
            acc_reg  <= '0;
            cnt_reg  <= ctl.count;
        end else if (run_reg) begin
            if (b_sh_reg[0]) begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
            cnt_reg  <= cnt_reg - stp_pkg::CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

[rtl/stp_serial_div.sv]
`default_nettype none

module stp_serial_div #(
    parameter int DEN_W = 34,
    parameter int LO_W  = 26
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire stp_pkg::unit_ctl_t    ctl,
    input  wire logic [DEN_W-1:0]      r_init,
    input  wire logic [LO_W-1:0]       lo_in,
    input  wire logic [DEN_W-1:0]      den_in,
    output logic                       done,
    output logic [LO_W-1:0]            quo
);

    logic [DEN_W-1:0]          r_reg;
    logic [LO_W-1:0]           lo_reg;
    logic [LO_W-1:0]           q_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [stp_pkg::CNT_W-1:0] cnt_reg;
    logic                      run_reg;
    logic                      done_reg;

    logic [DEN_W:0] r_sh;
    logic [DEN_W:0] r_sub;
    logic           ge;

    // restoring division, one quotient bit per cycle; r_init must be below den
    assign r_sh  = {r_reg, lo_reg[LO_W-1]};
    assign r_sub = r_sh - {1'b0, den_reg};
    assign ge    = r_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                run_reg <= 1'b1;
            end else if (run_reg && cnt_reg == stp_pkg::CNT_W'(1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            r_reg   <= r_init;
            lo_reg  <= lo_in;
            q_reg   <= '0;
            den_reg <= den_in;
            cnt_reg <= ctl.count;
        end else if (run_reg) begin
            r_reg   <= ge ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
            lo_reg  <= lo_reg << 1;
            q_reg   <= {q_reg[LO_W-2:0], ge};
            cnt_reg <= cnt_reg - stp_pkg::CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

[rtl/stepper_trapezoid_ramp.sv]
// Sequence: a move word and an active tick run the period multiply and, unless the period
// saturates, the period divide; an idle tick only computes the reload value before m_tvalid.
// Throughput: one word at a time; the work is done by the bit-serial multiplier
// (one multiplier bit per cycle) and the restoring divider (one quotient bit per cycle).
// Reset: synchronous, active low; config returns to defaults, the axis to position 0,
// idle, velocity 2 mm/s and a 0.01 s step period.
`default_nettype none

module stepper_trapezoid_ramp #(
    parameter int RELOAD_BITS   = stp_pkg::RELOAD_BITS_DEF,
    parameter int VEL_FRAC_BITS = stp_pkg::VEL_FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // target_mm[15:0], nominal_speed[23:16]
    input  wire logic [23:0]                       s_tdata,
    // op
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // reload_value, direction, moving, position_steps, zero fill
    output logic [((RELOAD_BITS+22+7)/8)*8-1:0]    m_tdata,
    // move_done
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [stp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [stp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int F       = VEL_FRAC_BITS;
    localparam int VW      = stp_pkg::SPD_W + F;
    localparam int MUL_AW  = (VW > stp_pkg::PERIOD_W) ? VW : stp_pkg::PERIOD_W;
    localparam int MUL_BW  = stp_pkg::TS_W;
    localparam int PW      = MUL_AW + MUL_BW;
    localparam int DEN_W   = stp_pkg::SPM_W + VW;
    localparam int LO_W    = stp_pkg::RAMP_W;
    localparam int D_W     = stp_pkg::TGT_W + stp_pkg::SPM_W + 2;
    localparam int NP_W    = stp_pkg::STEPS_W + 2;
    localparam int DVP_W   = stp_pkg::ACC_W + stp_pkg::PERIOD_W;
    localparam int DV_W    = DVP_W - (stp_pkg::PERIOD_W - F);
    localparam int NV_W    = VW + 4;
    localparam int RL_CW   = (RELOAD_BITS > stp_pkg::PERIOD_W) ? RELOAD_BITS
                                                               : stp_pkg::PERIOD_W;
    localparam int M_W     = ((RELOAD_BITS + 22 + 7) / 8) * 8;
    localparam logic [DEN_W-1:0] PER_ONE = DEN_W'(1) << F;

    // config
    logic [stp_pkg::ACC_W-1:0] accel_cfg_reg;
    logic [stp_pkg::SPD_W-1:0] min_cfg_reg;
    logic [stp_pkg::SPD_W-1:0] max_cfg_reg;
    logic [stp_pkg::SPM_W-1:0] spm_cfg_reg;
    logic [stp_pkg::TS_W-1:0]  ts_cfg_reg;

    // axis state
    logic [stp_pkg::POS_W-1:0]    pos_reg;
    logic [stp_pkg::STEPS_W-1:0]  total_reg;
    logic [stp_pkg::STEPS_W-1:0]  accel_end_reg;
    logic [stp_pkg::STEPS_W-1:0]  decel_start_reg;
    logic [stp_pkg::STEPS_W-1:0]  step_cnt_reg;
    logic [VW-1:0]                vel_reg;
    logic [stp_pkg::PERIOD_W-1:0] period_reg;
    logic                         dir_reg;
    logic                         active_reg;

    // current word and scratch
    logic                         op_reg;
    logic [stp_pkg::TGT_W-1:0]    tgt_reg;
    logic [stp_pkg::SPD_W-1:0]    nom_reg;
    logic                         done_flag_reg;
    logic [D_W-1:0]               dist_reg;
    logic [NV_W-1:0]              nv_reg;

    // output register
    logic                         m_valid_reg;
    logic [RELOAD_BITS-1:0]       rl_out_reg;
    logic                         dir_out_reg;
    logic                         mov_out_reg;
    logic                         last_out_reg;
    logic [stp_pkg::POS_W-1:0]    pos_out_reg;

    stp_pkg::state_t state_reg, state_next;

    stp_pkg::unit_ctl_t mul_ctl;
    logic [MUL_AW-1:0]  mul_a;
    logic [MUL_BW-1:0]  mul_b;
    logic               mul_done;
    logic [PW-1:0]      mul_prod;

    stp_pkg::unit_ctl_t div_ctl;
    logic [DEN_W-1:0]   div_rinit;
    logic [LO_W-1:0]    div_lo;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [LO_W-1:0]    div_q;

    logic out_load;

    stp_serial_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    stp_serial_div #(.DEN_W(DEN_W), .LO_W(LO_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .r_init  (div_rinit),
        .lo_in   (div_lo),
        .den_in  (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    // ---------------------------------------------------------------- datapath terms
    logic [stp_pkg::TGT_W-1:0]   tgt_mag;
    logic [D_W-1:0]              prod_mag;
    logic [D_W-1:0]              prod_sgn;
    logic [D_W-1:0]              dist_mag;
    logic [stp_pkg::STEPS_W-1:0] total_new;
    logic                        dir_new;
    logic [NP_W-1:0]             np_u;
    logic [stp_pkg::POS_W-1:0]   pos_new;
    logic [stp_pkg::ACC_W-1:0]   accel_eff;
    logic [stp_pkg::POS_W-1:0]   half_span;
    logic [stp_pkg::STEPS_W-1:0] accel_end_new;
    logic [stp_pkg::SPD_W-1:0]   start_spd;
    logic [DV_W-1:0]             dv;
    logic [NV_W-1:0]             nv_new;
    logic [NV_W-1:0]             lo_w;
    logic [NV_W-1:0]             hi_w;
    logic [NV_W-1:0]             nv_lo;
    logic [VW-1:0]               vel_clamped;
    logic                        per_sat;
    logic [stp_pkg::PERIOD_W-1:0] rl_raw;
    logic [RL_CW-1:0]            rl_wide;
    logic [RL_CW-1:0]            rl_max;
    logic [RELOAD_BITS-1:0]      rl_new;

    assign tgt_mag  = tgt_reg[stp_pkg::TGT_W-1] ? stp_pkg::TGT_W'(-tgt_reg) : tgt_reg;
    assign prod_mag = D_W'(mul_prod[stp_pkg::TGT_W+stp_pkg::SPM_W-1:0]);
    assign prod_sgn = tgt_reg[stp_pkg::TGT_W-1] ? (~prod_mag + D_W'(1)) : prod_mag;

    assign dist_mag  = dist_reg[D_W-1] ? (~dist_reg + D_W'(1)) : dist_reg;
    assign total_new = (dist_mag > D_W'(stp_pkg::STEPS_MAX)) ? stp_pkg::STEPS_MAX
                                                             : dist_mag[stp_pkg::STEPS_W-1:0];
    assign dir_new   = !dist_reg[D_W-1] && (dist_reg != '0);

    assign np_u    = dir_reg ? (NP_W'(pos_reg) + NP_W'(total_reg))
                             : (NP_W'(pos_reg) - NP_W'(total_reg));
    assign pos_new = np_u[NP_W-1] ? '0 :
                     (np_u > NP_W'(stp_pkg::POS_MAX)) ? stp_pkg::POS_MAX
                                                      : np_u[stp_pkg::POS_W-1:0];

    assign accel_eff = (accel_cfg_reg == '0) ? stp_pkg::ACC_W'(1) : accel_cfg_reg;
    assign half_span = total_reg[stp_pkg::STEPS_W-1:1];
    assign accel_end_new = (div_q < LO_W'(half_span)) ? div_q[stp_pkg::STEPS_W-1:0]
                                                      : stp_pkg::STEPS_W'(half_span);
    assign start_spd = (min_cfg_reg > max_cfg_reg) ? max_cfg_reg : min_cfg_reg;

    assign dv = mul_prod[DVP_W-1:stp_pkg::PERIOD_W-F];
    assign nv_new = (step_cnt_reg < accel_end_reg)   ? (NV_W'(vel_reg) + NV_W'(dv)) :
                    (step_cnt_reg > decel_start_reg) ? (NV_W'(vel_reg) - NV_W'(dv)) :
                                                       NV_W'(vel_reg);

    assign lo_w  = NV_W'({min_cfg_reg, {F{1'b0}}});
    assign hi_w  = NV_W'({max_cfg_reg, {F{1'b0}}});
    assign nv_lo = ($signed(nv_reg) < $signed(lo_w)) ? lo_w : nv_reg;
    assign vel_clamped = ($signed(nv_lo) > $signed(hi_w)) ? hi_w[VW-1:0] : nv_lo[VW-1:0];

    assign per_sat = mul_prod[DEN_W-1:0] <= PER_ONE;

    assign rl_raw  = mul_prod[stp_pkg::PERIOD_W+stp_pkg::TS_W-1:stp_pkg::TS_W];
    assign rl_wide = RL_CW'(rl_raw);
    assign rl_max  = RL_CW'({RELOAD_BITS{1'b1}});
    assign rl_new  = RELOAD_BITS'((rl_wide > rl_max) ? rl_max : rl_wide);

    assign out_load = (state_reg == stp_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == stp_pkg::OP_MOVE) begin
                        state_next = stp_pkg::ST_MV_TGT_GO;
                    end else if (active_reg) begin
                        state_next = stp_pkg::ST_TK_DV_GO;
                    end else begin
                        state_next = stp_pkg::ST_RL_GO;
                    end
                end
            end
            stp_pkg::ST_MV_TGT_GO:   state_next = stp_pkg::ST_MV_TGT_WAIT;
            stp_pkg::ST_MV_TGT_WAIT: if (mul_done) state_next = stp_pkg::ST_MV_DIST;
            stp_pkg::ST_MV_DIST:     state_next = stp_pkg::ST_MV_SQ_GO;
            stp_pkg::ST_MV_SQ_GO:    state_next = stp_pkg::ST_MV_SQ_WAIT;
            stp_pkg::ST_MV_SQ_WAIT:  if (mul_done) state_next = stp_pkg::ST_MV_SPM_GO;
            stp_pkg::ST_MV_SPM_GO:   state_next = stp_pkg::ST_MV_SPM_WAIT;
            stp_pkg::ST_MV_SPM_WAIT: if (mul_done) state_next = stp_pkg::ST_MV_RAMP_GO;
            stp_pkg::ST_MV_RAMP_GO:  state_next = stp_pkg::ST_MV_RAMP_WAIT;
            stp_pkg::ST_MV_RAMP_WAIT: if (div_done) state_next = stp_pkg::ST_MV_RAMP_SET;
            stp_pkg::ST_MV_RAMP_SET: state_next = stp_pkg::ST_PER_GO;
            stp_pkg::ST_TK_DV_GO:    state_next = stp_pkg::ST_TK_DV_WAIT;
            stp_pkg::ST_TK_DV_WAIT:  if (mul_done) state_next = stp_pkg::ST_TK_NV;
            stp_pkg::ST_TK_NV:       state_next = stp_pkg::ST_TK_VEL;
            stp_pkg::ST_TK_VEL:      state_next = stp_pkg::ST_PER_GO;
            stp_pkg::ST_PER_GO:      state_next = stp_pkg::ST_PER_MUL_WAIT;
            stp_pkg::ST_PER_MUL_WAIT: if (mul_done) state_next = stp_pkg::ST_PER_CHK;
            stp_pkg::ST_PER_CHK: begin
                state_next = per_sat ? stp_pkg::ST_FIN : stp_pkg::ST_PER_DIV_GO;
            end
            stp_pkg::ST_PER_DIV_GO:  state_next = stp_pkg::ST_PER_DIV_WAIT;
            stp_pkg::ST_PER_DIV_WAIT: if (div_done) state_next = stp_pkg::ST_FIN;
            stp_pkg::ST_FIN:         state_next = stp_pkg::ST_RL_GO;
            stp_pkg::ST_RL_GO:       state_next = stp_pkg::ST_RL_WAIT;
            stp_pkg::ST_RL_WAIT:     if (mul_done) state_next = stp_pkg::ST_OUT;
            stp_pkg::ST_OUT:         if (out_load) state_next = stp_pkg::ST_IDLE;
            default:                 state_next = stp_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_ctl   = '0;
        mul_a     = '0;
        mul_b     = '0;
        div_ctl   = '0;
        div_rinit = '0;
        div_lo    = '0;
        div_den   = '0;
        unique case (state_reg)
            stp_pkg::ST_IDLE: s_tready = 1'b1;
            stp_pkg::ST_MV_TGT_GO: begin
                mul_ctl = '{start: 1'b1, count: stp_pkg::CNT_SPM};
                mul_a   = MUL_AW'(tgt_mag);
                mul_b   = MUL_BW'(spm_cfg_reg);
            end
            stp_pkg::ST_MV_SQ_GO: begin
                mul_ctl = '{start: 1'b1, count: stp_pkg::CNT_SPD};
                mul_a   = MUL_AW'(nom_reg);
                mul_b   = MUL_BW'(nom_reg);
            end
            stp_pkg::ST_MV_SPM_GO: begin
                mul_ctl = '{start: 1'b1, count: stp_pkg::CNT_SPM};
                mul_a   = MUL_AW'(mul_prod[2*stp_pkg::SPD_W-1:0]);
                mul_b   = MUL_BW'(spm_cfg_reg);
            end
            stp_pkg::ST_MV_RAMP_GO: begin
                div_ctl = '{start: 1'b1, count: stp_pkg::CNT_RAMP};
                div_lo  = mul_prod[LO_W-1:0];
                div_den = DEN_W'({accel_eff, 1'b0});
            end
            stp_pkg::ST_TK_DV_GO: begin
                mul_ctl = '{start: 1'b1, count: stp_pkg::CNT_ACC};
                mul_a   = MUL_AW'(period_reg);
                mul_b   = MUL_BW'(accel_cfg_reg);
            end
            stp_pkg::ST_PER_GO: begin
                mul_ctl = '{start: 1'b1, count: stp_pkg::CNT_SPM};
                mul_a   = MUL_AW'(vel_reg);
                mul_b   = MUL_BW'(spm_cfg_reg);
            end
            stp_pkg::ST_PER_DIV_GO: begin
                div_ctl   = '{start: 1'b1, count: stp_pkg::CNT_PER};
                div_rinit = PER_ONE;
                div_den   = mul_prod[DEN_W-1:0];
            end
            stp_pkg::ST_RL_GO: begin
                mul_ctl = '{start: 1'b1, count: stp_pkg::CNT_TS};
                mul_a   = MUL_AW'(period_reg);
                mul_b   = ts_cfg_reg;
            end
            stp_pkg::ST_MV_TGT_WAIT, stp_pkg::ST_MV_DIST, stp_pkg::ST_MV_SQ_WAIT,
            stp_pkg::ST_MV_SPM_WAIT, stp_pkg::ST_MV_RAMP_WAIT, stp_pkg::ST_MV_RAMP_SET,
            stp_pkg::ST_TK_DV_WAIT, stp_pkg::ST_TK_NV, stp_pkg::ST_TK_VEL,
            stp_pkg::ST_PER_MUL_WAIT, stp_pkg::ST_PER_CHK, stp_pkg::ST_PER_DIV_WAIT,
            stp_pkg::ST_FIN, stp_pkg::ST_RL_WAIT, stp_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_cfg_reg <= stp_pkg::ACCEL_RST;
            min_cfg_reg   <= stp_pkg::MIN_SPEED_RST;
            max_cfg_reg   <= stp_pkg::MAX_SPEED_RST;
            spm_cfg_reg   <= stp_pkg::STEPS_MM_RST;
            ts_cfg_reg    <= stp_pkg::TIMER_SC_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                stp_pkg::REG_ACCEL:     accel_cfg_reg <= cfg_data[stp_pkg::ACC_W-1:0];
                stp_pkg::REG_MIN_SPEED: min_cfg_reg   <= cfg_data[stp_pkg::SPD_W-1:0];
                stp_pkg::REG_MAX_SPEED: max_cfg_reg   <= cfg_data[stp_pkg::SPD_W-1:0];
                stp_pkg::REG_STEPS_MM:  spm_cfg_reg   <= cfg_data[stp_pkg::SPM_W-1:0];
                stp_pkg::REG_TIMER_SC:  ts_cfg_reg    <= cfg_data[stp_pkg::TS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            total_reg       <= '0;
            accel_end_reg   <= '0;
            decel_start_reg <= '0;
            step_cnt_reg    <= '0;
            vel_reg         <= VW'({stp_pkg::VEL_RST_MM_S, {F{1'b0}}});
            period_reg      <= stp_pkg::PERIOD_RST;
            dir_reg         <= 1'b0;
            active_reg      <= 1'b0;
            done_flag_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                stp_pkg::ST_IDLE: if (s_tvalid) done_flag_reg <= 1'b0;
                stp_pkg::ST_MV_SQ_GO: begin
                    total_reg <= total_new;
                    dir_reg   <= dir_new;
                end
                stp_pkg::ST_MV_SPM_GO: pos_reg <= pos_new;
                stp_pkg::ST_MV_RAMP_SET: begin
                    accel_end_reg <= accel_end_new;
                    step_cnt_reg  <= '0;
                    vel_reg       <= VW'({start_spd, {F{1'b0}}});
                    active_reg    <= 1'b1;
                end
                stp_pkg::ST_TK_DV_GO: step_cnt_reg <= step_cnt_reg + stp_pkg::STEPS_W'(1);
                stp_pkg::ST_TK_VEL:   vel_reg <= vel_clamped;
                stp_pkg::ST_PER_GO:   decel_start_reg <= total_reg - accel_end_reg;
                stp_pkg::ST_PER_CHK:  if (per_sat) period_reg <= stp_pkg::PERIOD_MAX;
                stp_pkg::ST_PER_DIV_WAIT: begin
                    if (div_done) period_reg <= div_q[stp_pkg::PERIOD_W-1:0];
                end
                stp_pkg::ST_FIN: begin
                    if (op_reg == stp_pkg::OP_TICK && step_cnt_reg >= total_reg) begin
                        step_cnt_reg  <= '0;
                        active_reg    <= 1'b0;
                        done_flag_reg <= 1'b1;
                    end
                end
                stp_pkg::ST_MV_TGT_GO, stp_pkg::ST_MV_TGT_WAIT, stp_pkg::ST_MV_DIST,
                stp_pkg::ST_MV_SQ_WAIT, stp_pkg::ST_MV_SPM_WAIT, stp_pkg::ST_MV_RAMP_GO,
                stp_pkg::ST_MV_RAMP_WAIT, stp_pkg::ST_TK_DV_WAIT, stp_pkg::ST_TK_NV,
                stp_pkg::ST_PER_MUL_WAIT, stp_pkg::ST_PER_DIV_GO, stp_pkg::ST_RL_GO,
                stp_pkg::ST_RL_WAIT, stp_pkg::ST_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // word and scratch payload
    always_ff @(posedge aclk) begin
        if (state_reg == stp_pkg::ST_IDLE && s_tvalid) begin
            op_reg  <= s_tuser;
            tgt_reg <= s_tdata[stp_pkg::TGT_W-1:0];
            nom_reg <= s_tdata[stp_pkg::TGT_W+stp_pkg::SPD_W-1:stp_pkg::TGT_W];
        end
        if (state_reg == stp_pkg::ST_MV_DIST) begin
            dist_reg <= prod_sgn - D_W'(pos_reg);
        end
        if (state_reg == stp_pkg::ST_TK_NV) begin
            nv_reg <= nv_new;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            rl_out_reg   <= rl_new;
            dir_out_reg  <= dir_reg;
            mov_out_reg  <= active_reg;
            last_out_reg <= done_flag_reg;
            pos_out_reg  <= pos_reg;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_W'({pos_out_reg, mov_out_reg, dir_out_reg, rl_out_reg});
    assign m_tlast   = last_out_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

[rtl/stp_checker.sv]
`default_nettype none

module stp_checker #(
    parameter int RELOAD_BITS = stp_pkg::RELOAD_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic                                s_tuser,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [((RELOAD_BITS+22+7)/8)*8-1:0] m_tdata,
    input  wire logic                                m_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // a finished move never reports itself as still moving
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[RELOAD_BITS+1])
        else $error("move_done with moving set");

    // one word in flight: input closes right after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in work");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    logic unused_tuser;
    assign unused_tuser = s_tuser;

endmodule

bind stepper_trapezoid_ramp stp_checker #(.RELOAD_BITS(RELOAD_BITS)) u_stp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[dv/tb_stepper_trapezoid_ramp.sv]
`default_nettype none

module tb_stepper_trapezoid_ramp;
    import stp_pkg::*;

    localparam int RB          = RELOAD_BITS_DEF;
    localparam int VF          = VEL_FRAC_BITS_DEF;
    localparam int MD_W        = ((RB + 22 + 7) / 8) * 8;
    localparam int STALL_LIMIT = 3000;
    localparam int RAND_WORDS  = 1750;

    typedef struct packed {
        logic [RB-1:0]    reload;
        logic             dir;
        logic             moving;
        logic             done;
        logic [POS_W-1:0] pos;
    } ramp_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [MD_W-1:0]       m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // mirror of the axis configuration and motion state
    logic [ACC_W-1:0]    c_accel = ACCEL_RST;
    logic [SPD_W-1:0]    c_min   = MIN_SPEED_RST;
    logic [SPD_W-1:0]    c_max   = MAX_SPEED_RST;
    logic [SPM_W-1:0]    c_spm   = STEPS_MM_RST;
    logic [TS_W-1:0]     c_ts    = TIMER_SC_RST;
    logic [POS_W-1:0]    p_pos       = '0;
    logic [STEPS_W-1:0]  p_total     = '0;
    logic [STEPS_W-1:0]  p_acc_end   = '0;
    logic [STEPS_W-1:0]  p_dec_start = '0;
    logic [STEPS_W-1:0]  p_count     = '0;
    logic [23:0]         p_vel       = 24'(VEL_RST_MM_S) << VF;
    logic [PERIOD_W-1:0] p_period    = PERIOD_RST;
    logic                p_dir       = 1'b0;
    logic                p_active    = 1'b0;

    ramp_out_t pending_ramp_out[$];
    ramp_out_t want;
    int        errors       = 0;
    int        quiet_cycles = 0;
    int        rx_hold      = 0;
    bit        steady       = 1'b0;

    stepper_trapezoid_ramp u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [23:0] vel_limit(longint v);
        longint lo, hi;
        lo = longint'(c_min) << VF;
        hi = longint'(c_max) << VF;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v[23:0];
    endfunction

    function automatic logic [PERIOD_W-1:0] period_for(logic [23:0] vel);
        logic [63:0] den, q;
        den = 64'(c_spm) * 64'(vel);
        if (den == 0) return PERIOD_MAX;
        q = (64'd1 << (24 + VF)) / den;
        return (q > 64'(PERIOD_MAX)) ? PERIOD_MAX : q[PERIOD_W-1:0];
    endfunction

    function automatic ramp_out_t ramp_predict(logic op, logic [TGT_W-1:0] tgt,
                                               logic [SPD_W-1:0] spd);
        ramp_out_t   o;
        longint      d, np, nv, dv;
        logic [63:0] mag, ramp, half, a, r;
        logic        done;
        done = 1'b0;
        if (op == OP_MOVE) begin
            d = longint'(signed'(tgt)) * longint'(c_spm) - longint'(p_pos);
            mag = (d < 0) ? -d : d;
            p_total = (mag > 64'(STEPS_MAX)) ? STEPS_MAX : mag[STEPS_W-1:0];
            p_dir = (d > 0);
            np = p_dir ? longint'(p_pos) + longint'(p_total)
                       : longint'(p_pos) - longint'(p_total);
            if (np < 0) np = 0;
            if (np > longint'(POS_MAX)) np = longint'(POS_MAX);
            p_pos = np[POS_W-1:0];
            a = (c_accel == 0) ? 64'd1 : 64'(c_accel);
            ramp = 64'(spd) * 64'(spd) * 64'(c_spm) / (64'd2 * a);
            half = 64'(p_total >> 1);
            p_acc_end = (ramp < half) ? ramp[STEPS_W-1:0] : half[STEPS_W-1:0];
            p_dec_start = p_total - p_acc_end;
            p_count = '0;
            p_vel = vel_limit(longint'(c_min) << VF);
            p_period = period_for(p_vel);
            p_active = 1'b1;
        end else if (p_active) begin
            dv = longint'((64'(c_accel) * 64'(p_period)) >> (24 - VF));
            nv = longint'(p_vel);
            p_count = p_count + 1'b1;
            if (p_count < p_acc_end) nv = nv + dv;
            else if (p_count > p_dec_start) nv = nv - dv;
            p_vel = vel_limit(nv);
            p_period = period_for(p_vel);
            if (p_count >= p_total) begin
                p_count = '0;
                p_active = 1'b0;
                done = 1'b1;
            end
        end
        r = (64'(p_period) * 64'(c_ts)) >> 24;
        o.reload = (r > 64'((1 << RB) - 1)) ? RB'((1 << RB) - 1) : r[RB-1:0];
        o.dir = p_dir;
        o.moving = p_active;
        o.done = done;
        o.pos = p_pos;
        return o;
    endfunction

    task automatic send_word(logic op, logic [TGT_W-1:0] tgt, logic [SPD_W-1:0] spd);
        @(negedge aclk);
        if (!steady && $urandom_range(0, 99) < 11) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {spd, tgt};
        do @(posedge aclk); while (!s_tready);
        pending_ramp_out.push_back(ramp_predict(op, tgt, spd));
    endtask

    task automatic send_tick();
        send_word(OP_TICK, TGT_W'($urandom), SPD_W'($urandom));
    endtask

    // hold off the sender until every result is back and the block is idle
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_ramp_out.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ACCEL:     c_accel = val[ACC_W-1:0];
            REG_MIN_SPEED: c_min = val[SPD_W-1:0];
            REG_MAX_SPEED: c_max = val[SPD_W-1:0];
            REG_STEPS_MM:  c_spm = val[SPM_W-1:0];
            REG_TIMER_SC:  c_ts = val[TS_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_config(logic [ACC_W-1:0] acc, logic [SPD_W-1:0] mn,
                                logic [SPD_W-1:0] mx, logic [SPM_W-1:0] spm,
                                logic [TS_W-1:0] ts);
        settle();
        write_reg(REG_ACCEL, CFG_DATA_W'(acc));
        write_reg(REG_MIN_SPEED, CFG_DATA_W'(mn));
        write_reg(REG_MAX_SPEED, CFG_DATA_W'(mx));
        write_reg(REG_STEPS_MM, CFG_DATA_W'(spm));
        write_reg(REG_TIMER_SC, CFG_DATA_W'(ts));
    endtask

    task automatic step_until_idle(input int cap, inout int n);
        int k;
        k = 0;
        while (p_active && k < cap) begin
            send_tick();
            k++;
        end
        n += k;
    endtask

    task automatic test_reset_state();
        int n;
        n = 0;
        send_tick();
        send_word(OP_MOVE, 16'sd0, 8'd0);
        send_tick();
        send_tick();
    endtask

    task automatic test_short_profile();
        int n;
        n = 0;
        write_config(10'd1023, 8'd1, 8'd255, 10'd1, 24'd2000000);
        send_word(OP_MOVE, 16'sd3, 8'd255);
        step_until_idle(8, n);
        send_word(OP_MOVE, 16'h8000, 8'd0);
        send_tick();
        send_word(OP_MOVE, 16'h7FFF, 8'd255);
        send_tick();
        send_tick();
        send_word(OP_MOVE, 16'h7FFF, 8'd128);
        send_tick();
    endtask

    task automatic test_config_extremes();
        int n;
        n = 0;
        // min above max, zero acceleration, widest scale factors
        write_config(10'd0, 8'd255, 8'd1, 10'd1023, 24'hFFFFFF);
        send_word(OP_MOVE, 16'h7FFF, 8'd255);
        send_tick();
        send_word(OP_MOVE, 16'h8000, 8'd255);
        send_tick();
        // zero steps per mm and zero velocity
        write_config(10'd0, 8'd0, 8'd0, 10'd0, 24'd1);
        send_word(OP_MOVE, 16'sd7, 8'd1);
        send_tick();
        write_config(10'd512, 8'd0, 8'd0, 10'd3, 24'd1);
        send_word(OP_MOVE, 16'sd1, 8'd9);
        step_until_idle(8, n);
    endtask

    task automatic test_random_profiles();
        int counted, phase, phase_end, pick, near, dmax, tgt, ticks, r;
        logic [ACC_W-1:0]  acc;
        logic [SPD_W-1:0]  mn, mx;
        logic [SPM_W-1:0]  spm;
        logic [TS_W-1:0]   ts;
        logic              was_active;
        counted = 0;
        phase = 0;
        while (counted < RAND_WORDS) begin
            r = $urandom_range(0, 99);
            spm = (r < 70) ? SPM_W'($urandom_range(1, 6)) :
                  (r < 90) ? SPM_W'($urandom_range(7, 64)) :
                             SPM_W'($urandom_range(65, 1023));
            r = $urandom_range(0, 9);
            acc = (r == 0) ? 10'd1 : (r == 1) ? 10'd1023 : ACC_W'($urandom_range(1, 1023));
            mn = ($urandom_range(0, 9) < 7) ? SPD_W'($urandom_range(1, 8))
                                            : SPD_W'($urandom_range(1, 255));
            mx = SPD_W'($urandom_range(1, 255));
            r = $urandom_range(0, 9);
            ts = (r == 0) ? 24'd1 : (r == 1) ? 24'hFFFFFF : TS_W'($urandom_range(1, 24'hFFFFFF));
            write_config(acc, mn, mx, spm, ts);
            steady = (phase == 2);
            phase_end = counted + 250;
            while (counted < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    if (int'(p_pos) / int'(c_spm) > 32767) begin
                        send_word(OP_MOVE, 16'sd0, SPD_W'($urandom));
                        counted++;
                    end
                    near = int'(p_pos) / int'(c_spm);
                    dmax = 150 / int'(c_spm);
                    tgt = near + $urandom_range(0, 2 * dmax) - dmax;
                    if (tgt > 32767) tgt = 32767;
                    if (tgt < -32768) tgt = -32768;
                    send_word(OP_MOVE, TGT_W'(tgt), SPD_W'($urandom));
                    counted++;
                    ticks = ($urandom_range(0, 4) == 0 || p_total > 300)
                            ? $urandom_range(0, 12) : 400;
                    step_until_idle(ticks, counted);
                    if ($urandom_range(0, 9) == 0) send_tick();
                end else if (pick < 85) begin
                    was_active = p_active;
                    send_tick();
                    if (was_active) counted++;
                end else if (pick < 95) begin
                    send_word(OP_MOVE, TGT_W'($urandom), SPD_W'($urandom));
                    counted++;
                    step_until_idle($urandom_range(0, 5), counted);
                end else begin
                    settle();
                end
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready = 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 11) begin
            m_tready = 1'b0;
            rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 0;
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic check_field(string name, logic [31:0] expv, logic [31:0] got);
        if (got !== expv) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ramp_out.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h", $time,
                         m_tdata);
                errors++;
            end else begin
                want = pending_ramp_out.pop_front();
                check_field("reload_value", 32'(want.reload), 32'(m_tdata[RB-1:0]));
                check_field("direction", 32'(want.dir), 32'(m_tdata[RB]));
                check_field("moving", 32'(want.moving), 32'(m_tdata[RB+1]));
                check_field("position_steps", 32'(want.pos), 32'(m_tdata[RB+2 +: POS_W]));
                check_field("move_done", 32'(want.done), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_MOVE;
        cfg_valid = 1'b0;
        cfg_index = REG_ACCEL;
        cfg_data = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_short_profile();
        test_config_extremes();
        test_random_profiles();

        settle();
        repeat (150) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/stp_pkg.sv
rtl/stp_serial_mul.sv
rtl/stp_serial_div.sv
rtl/stepper_trapezoid_ramp.sv
rtl/stp_checker.sv
dv/tb_stepper_trapezoid_ramp.sv
